// ===== rtl/core/fcpm_pkg.sv =====
`timescale 1ns / 1ps

package fcpm_pkg;

    localparam int PIX_W      = 24;
    localparam int TAG_W      = 12;
    localparam int THR_W      = 10;
    localparam int SNUM_W     = 12;
    localparam int SOFF_W     = 8;
    localparam int HMUL_W     = 4;
    localparam int SCORE_W    = 22;
    localparam int SUM_W      = 24;
    localparam int NUM_SQ     = 4;
    localparam int HUE_SHIFT  = 8;
    localparam int DEAD_SCORE = 1024;
    localparam int ADDR_W     = 5;
    localparam int S_DATA_W   = 120;
    localparam int M_DATA_W   = 32;
    // index of the output register stage; the input register is stage 0
    localparam int PIPE_LAST  = 36;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SAT_NUM   = 3'd1;
    localparam logic [2:0] REG_SAT_VOFF  = 3'd2;
    localparam logic [2:0] REG_SAT_HOFF  = 3'd3;
    localparam logic [2:0] REG_HUE_MULT  = 3'd4;

    localparam logic [1:0] COL_GREEN = 2'd0;
    localparam logic [1:0] COL_GB    = 2'd1;
    localparam logic [1:0] COL_RG    = 2'd2;
    localparam logic [1:0] COL_RB    = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SNUM_W-1:0] sat_num;
        logic [SOFF_W-1:0] sat_voff;
        logic [SOFF_W-1:0] sat_hoff;
        logic [HMUL_W-1:0] hue_mult;
    } cfg_t;

    typedef struct packed {
        logic       dead;
        logic [7:0] num;
        logic [8:0] den;
        logic [7:0] sat;
    } sq_prep_t;

    function automatic sq_prep_t sq_prep(input logic [PIX_W-1:0] px, input logic [1:0] col);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        sq_prep_t   p;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        p = '0;
        case (col)
            COL_GREEN:
            begin
                p.dead = (g <= r) || (g <= b);
                if (r > b)
                begin
                    p.sat = g - b; p.num = r - b; p.den = {1'b0, g - r};
                end
                else
                begin
                    p.sat = g - r; p.num = b - r; p.den = {1'b0, g - b};
                end
            end
            COL_GB:
            begin
                p.dead = (r >= g) || (r >= b);
                if (g > b)
                begin
                    p.sat = g - r; p.num = g - b; p.den = {1'b0, b - r};
                end
                else
                begin
                    p.sat = b - r; p.num = b - g; p.den = {1'b0, g - r};
                end
            end
            COL_RG:
            begin
                p.dead = (b >= r) || (b >= g);
                if (r > g)
                begin
                    p.sat = r - b; p.num = r - g; p.den = {1'b0, g - b} + 9'd1;
                end
                else
                begin
                    p.sat = g - b; p.num = g - r; p.den = {1'b0, r - b} + 9'd1;
                end
            end
            default:
            begin
                p.dead = (g >= r) || (g >= b);
                if (r > b)
                begin
                    p.sat = r - g; p.num = r - b; p.den = {1'b0, b - g};
                end
                else
                begin
                    p.sat = b - g; p.num = b - r; p.den = {1'b0, r - g};
                end
            end
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/four_color_pattern_matcher.sv =====
`timescale 1ns / 1ps

// Pipeline: input reg, prep, 12-stage hue and penalty dividers, 20-stage scaling
//   divider, score, sum, out.
// Throughput: one request per cycle; the whole pipeline holds while the output
//   register is full and m_tready is low.
// Reset: rst_n async active low clears valid bits and restores config defaults.
module four_color_pattern_matcher (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: corner_top_left, corner_top_right, corner_bottom_right,
    //        corner_bottom_left, centre_x, centre_y (low bit up)
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fcpm_pkg::S_DATA_W-1:0]   s_tdata,
    // tdata: matched, rotation, mark_x, mark_y, zero pad (low bit up)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fcpm_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcpm_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import fcpm_pkg::*;

    cfg_t cfg_reg;
    logic cfg_we;

    // pipeline advance: everything moves unless a result is stuck at the output
    logic en;
    logic vld_reg [0:PIPE_LAST];
    logic [2*TAG_W-1:0] tag_reg [0:PIPE_LAST];
    logic [PIX_W-1:0]   px_reg [0:NUM_SQ-1];

    logic signed [SCORE_W-1:0] score [0:NUM_SQ-1][0:NUM_SQ-1];
    logic signed [SUM_W-1:0]   sum_next [0:NUM_SQ-1];
    logic signed [SUM_W-1:0]   sum_reg  [0:NUM_SQ-1];
    logic                      matched_next;
    logic [1:0]                rot_next;
    logic                      matched_reg;
    logic [1:0]                rot_reg;
    logic signed [SUM_W-1:0]   thr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THR_W'(184);
            cfg_reg.sat_num   <= SNUM_W'(1024);
            cfg_reg.sat_voff  <= SOFF_W'(5);
            cfg_reg.sat_hoff  <= SOFF_W'(1);
            cfg_reg.hue_mult  <= HMUL_W'(3);
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_THRESHOLD: cfg_reg.threshold <= pwdata[THR_W-1:0];
                REG_SAT_NUM:   cfg_reg.sat_num   <= pwdata[SNUM_W-1:0];
                REG_SAT_VOFF:  cfg_reg.sat_voff  <= pwdata[SOFF_W-1:0];
                REG_SAT_HOFF:  cfg_reg.sat_hoff  <= pwdata[SOFF_W-1:0];
                REG_HUE_MULT:  cfg_reg.hue_mult  <= pwdata[HMUL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_THRESHOLD: prdata = 32'(cfg_reg.threshold);
            REG_SAT_NUM:   prdata = 32'(cfg_reg.sat_num);
            REG_SAT_VOFF:  prdata = 32'(cfg_reg.sat_voff);
            REG_SAT_HOFF:  prdata = 32'(cfg_reg.sat_hoff);
            REG_HUE_MULT:  prdata = 32'(cfg_reg.hue_mult);
            default:       prdata = '0;
        endcase
    end

    // ---------------- handshake and valid/tag pipe ----------------
    assign en       = !vld_reg[PIPE_LAST] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= PIPE_LAST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= PIPE_LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= s_tdata[4*PIX_W +: 2*TAG_W];
            for (int k = 1; k <= PIPE_LAST; k++)
                tag_reg[k] <= tag_reg[k-1];
            for (int k = 0; k < NUM_SQ; k++)
                px_reg[k] <= s_tdata[k*PIX_W +: PIX_W];
        end
    end

    // ---------------- 16 square scorers: corner c against color i ----------------
    for (genvar c = 0; c < NUM_SQ; c++)
    begin : g_corner
        for (genvar i = 0; i < NUM_SQ; i++)
        begin : g_color
            fcpm_square #(.COLOR(2'(i))) u_sq (
                .clk(clk), .en(en), .cfg(cfg_reg), .px(px_reg[c]),
                .score(score[c][i])
            );
        end
    end

    // rotation rot uses corner (rot+i) mod 4 for color i
    always_comb
    begin
        for (int rot = 0; rot < NUM_SQ; rot++)
        begin
            sum_next[rot] = '0;
            for (int i = 0; i < NUM_SQ; i++)
                sum_next[rot] = sum_next[rot] + SUM_W'(score[(rot + i) % NUM_SQ][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int rot = 0; rot < NUM_SQ; rot++)
                sum_reg[rot] <= sum_next[rot];
        end
    end

    // first rotation at or below the threshold wins; none gives rotation 0
    assign thr = $signed({{(SUM_W-THR_W){1'b0}}, cfg_reg.threshold});

    always_comb
    begin
        matched_next = 1'b0;
        rot_next     = 2'd0;
        for (int rot = NUM_SQ - 1; rot >= 0; rot--)
        begin
            if (sum_reg[rot] <= thr)
            begin
                matched_next = 1'b1;
                rot_next     = 2'(rot);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            matched_reg <= matched_next;
            rot_reg     <= rot_next;
        end
    end

    assign m_tdata = {5'd0, tag_reg[PIPE_LAST], rot_reg, matched_reg};

    // ---------------- assertions ----------------
    a_no_match_rot0: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == 2'd0))
        else $error("no-match result carries nonzero rotation");

    a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> ($stable(vld_reg[1]) && $stable(vld_reg[13]) && $stable(vld_reg[34])))
        else $error("valid bit moved during stall");

    a_valid_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[33]) |=> vld_reg[34])
        else $error("valid bit lost in pipe");

endmodule

// ===== rtl/core/fcpm_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, NW stages.
module fcpm_div #(
    parameter int NW = 12,
    parameter int DW = 9,
    parameter int XW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [XW-1:0] xin,
    output logic [NW-1:0] quo,
    output logic [XW-1:0] xout
);
    logic [DW-1:0] rem_reg [1:NW];
    logic [NW-1:0] qn_reg  [1:NW];
    logic [DW-1:0] d_reg   [1:NW];
    logic [XW-1:0] x_reg   [1:NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW-1:0] r_cur;
        logic [NW-1:0] q_cur;
        logic [DW-1:0] d_cur;
        logic [XW-1:0] x_cur;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        if (k == 0)
        begin : g_first
            assign r_cur = '0;
            assign q_cur = num;
            assign d_cur = den;
            assign x_cur = xin;
        end
        else
        begin : g_mid
            assign r_cur = rem_reg[k];
            assign q_cur = qn_reg[k];
            assign d_cur = d_reg[k];
            assign x_cur = x_reg[k];
        end

        assign trial = {r_cur, q_cur[NW-1]};
        assign ge    = trial >= {1'b0, d_cur};
        assign diff  = trial - {1'b0, d_cur};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                qn_reg[k+1]  <= {q_cur[NW-2:0], ge};
                d_reg[k+1]   <= d_cur;
                x_reg[k+1]   <= x_cur;
            end
        end
    end

    assign quo  = qn_reg[NW];
    assign xout = x_reg[NW];

endmodule

// ===== rtl/core/fcpm_square.sv =====
`timescale 1ns / 1ps

// Score of one corner against one reference color; 34 register stages.
module fcpm_square #(
    parameter logic [1:0] COLOR = 2'd0
) (
    input  logic                                clk,
    input  logic                                en,
    input  fcpm_pkg::cfg_t                      cfg,
    input  logic [fcpm_pkg::PIX_W-1:0]          px,
    output logic signed [fcpm_pkg::SCORE_W-1:0] score
);
    import fcpm_pkg::*;

    sq_prep_t         prep_reg;
    logic [11:0]      prod;
    logic [8:0]       sat_sum;
    logic [11:0]      hue1;
    logic [7:0]       sat1;
    logic [11:0]      pen1;
    logic             dead1;
    logic [19:0]      hue2;
    logic [12:0]      x2;
    logic signed [SCORE_W-1:0] score_next;
    logic signed [SCORE_W-1:0] score_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= sq_prep(px, COLOR);
        end
    end

    assign prod    = 12'(prep_reg.num) * 12'(cfg.hue_mult);
    assign sat_sum = {1'b0, prep_reg.sat} + {1'b0, cfg.sat_hoff};

    fcpm_div #(.NW(12), .DW(9), .XW(8)) u_hue_div (
        .clk(clk), .en(en), .num(prod), .den(prep_reg.den),
        .xin(prep_reg.sat), .quo(hue1), .xout(sat1)
    );

    fcpm_div #(.NW(12), .DW(9), .XW(1)) u_pen_div (
        .clk(clk), .en(en), .num(cfg.sat_num), .den(sat_sum),
        .xin(prep_reg.dead), .quo(pen1), .xout(dead1)
    );

    fcpm_div #(.NW(20), .DW(8), .XW(13)) u_scale_div (
        .clk(clk), .en(en), .num({hue1, HUE_SHIFT'(0)}), .den(sat1),
        .xin({dead1, pen1}), .quo(hue2), .xout(x2)
    );

    always_comb
    begin
        if (x2[12])
            score_next = SCORE_W'(DEAD_SCORE);
        else
            score_next = $signed({2'b00, hue2}) + $signed({10'd0, x2[11:0]})
                         - $signed({14'd0, cfg.sat_voff});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            score_reg <= score_next;
        end
    end

    assign score = score_reg;

endmodule
